// ----- sv/hdf_pkg.sv -----
// shared types and constants for the heading deviation filter
package hdf_pkg;

	localparam logic [11:0] HEADING_MAX = 12'd3599;

	// divide by 15 as multiply by ceil(2^18 / 15) and shift
	localparam logic [14:0] DIV15_RECIP = 15'd17477;

	localparam logic [7:0] HEADING_UNSET = 8'd240;
	localparam logic [7:0] TARGET_RESET = 8'd255;

	localparam logic signed [9:0] TURN_UNITS = 10'sd240;
	localparam logic signed [9:0] HALF_TURN = 10'sd120;
	localparam logic signed [9:0] ERR_LIMIT = 10'sd20;

	localparam logic [2:0] REG_COMPASS_GAIN = 3'd0;

	typedef struct packed {
		logic ok;
		logic [7:0] dir;
	} hdf_item_t;

endpackage

// ----- sv/hdf_intake.sv -----
// input register stage: saturates the raw heading and scales it to 240 units per turn
module hdf_intake import hdf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            heading_valid,
	output logic            heading_stall,
	input  logic            sensor_ok,
	input  logic [11:0]     heading_raw,
	input  logic            ready,
	output logic            valid_s1,
	output hdf_item_t       item_s1
);

	logic [11:0] raw_sat;
	logic [26:0] prod;

	assign raw_sat = (heading_raw > HEADING_MAX) ? HEADING_MAX : heading_raw;
	assign prod = {15'd0, raw_sat} * {12'd0, DIV15_RECIP};

	assign heading_stall = valid_s1 && !ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!heading_stall) begin
			valid_s1 <= heading_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (heading_valid && !heading_stall) begin
			item_s1.ok  <= sensor_ok;
			item_s1.dir <= prod[25:18];
		end
	end

endmodule

// ----- sv/hdf_core.sv -----
// target capture, error wrap and clamp, and the deviation filter state
module hdf_core import hdf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  hdf_item_t       item_s1,
	input  logic [7:0]      gain,
	output logic            ready,
	output logic            result_valid,
	input  logic            result_stall,
	output logic signed [7:0] deviation,
	output logic [7:0]      target_heading
);

	logic [7:0] tgt_q;
	logic [7:0] dev_q;
	logic       valid_q;
	logic       adv;
	logic       capture;
	logic [7:0] tgt_eff;
	logic [7:0] old_dev;
	logic signed [9:0] err_raw;
	logic signed [9:0] err_lo;
	logic signed [9:0] err_wrap;
	logic signed [9:0] err_lim;
	logic signed [10:0] old_ext;
	logic signed [10:0] sum;
	logic [15:0] sum16;
	logic [15:0] scaled;
	logic [23:0] prod;
	logic [7:0] tgt_next;
	logic [7:0] dev_next;

	assign ready = !valid_q || !result_stall;
	assign adv = valid_s1 && ready;

	assign capture = (tgt_q == HEADING_UNSET);
	assign tgt_eff = capture ? item_s1.dir : tgt_q;
	assign old_dev = capture ? 8'd0 : dev_q;

	assign err_raw = $signed({2'b00, tgt_eff}) - $signed({2'b00, item_s1.dir});
	assign err_lo = (err_raw <= -HALF_TURN) ? err_raw + TURN_UNITS : err_raw;
	assign err_wrap = (err_lo > HALF_TURN) ? err_lo - TURN_UNITS : err_lo;
	assign err_lim = (err_wrap > ERR_LIMIT) ? ERR_LIMIT :
		((err_wrap < -ERR_LIMIT) ? -ERR_LIMIT : err_wrap);

	assign old_ext = $signed({{3{old_dev[7]}}, old_dev});
	assign sum = (old_ext <<< 1) + old_ext + $signed({err_lim[9], err_lim});
	assign sum16 = {{5{sum[10]}}, sum};
	assign scaled = {sum16[13:0], 2'b00};
	assign prod = scaled * {8'd0, gain};

	always_comb begin
		tgt_next = tgt_q;
		dev_next = 8'd0;
		if (item_s1.ok) begin
			if (tgt_q > HEADING_UNSET) begin
				tgt_next = tgt_q - 8'd1;
			end else begin
				tgt_next = tgt_eff;
				dev_next = prod[15:8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q   <= TARGET_RESET;
			dev_q   <= 8'd0;
			valid_q <= 1'b0;
		end else begin
			if (ready) begin
				valid_q <= valid_s1;
			end
			if (adv) begin
				tgt_q <= tgt_next;
				dev_q <= dev_next;
			end
		end
	end

	assign result_valid = valid_q;
	assign deviation = $signed(dev_q);
	assign target_heading = tgt_q;

`ifndef ASSERT_OFF
	a_absent_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !item_s1.ok |=> dev_q == 8'd0)
		else $error("deviation not cleared for absent sensor");

	a_countdown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tgt_q > HEADING_UNSET |-> dev_q == 8'd0)
		else $error("deviation nonzero during countdown");

	a_countdown_falls: assert property (@(posedge clk) disable iff (!arst_n)
		tgt_q > HEADING_UNSET |=> tgt_q <= $past(tgt_q))
		else $error("countdown value rose");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(tgt_q) && $stable(dev_q))
		else $error("state changed without a beat");
`endif

endmodule

// ----- sv/heading_deviation_filter.sv -----
// Heading deviation filter top level. Each accepted beat is one compass reading;
// it produces exactly one result beat carrying the new signed deviation and the
// stored target (or startup countdown value). One reading can be accepted every
// cycle while results are taken. A reading is accepted into the input register,
// and its result is presented once it has moved on into the deviation and target
// registers. On its way into the input register the heading is saturated and
// scaled by a reciprocal multiply. Between that register and the deviation and
// target registers sit the error wrap and the gain multiply. Those registers
// close the recurrence and drive the result. A stalled result holds the input
// register, so the next reading is stalled in the same cycle.
// compass_gain sits at byte address 0 of the APB port and should be written
// while the block is idle.
module heading_deviation_filter import hdf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              heading_valid,
	output logic              heading_stall,
	input  logic              sensor_ok,
	input  logic [11:0]       heading_raw,
	output logic              result_valid,
	input  logic              result_stall,
	output logic signed [7:0] deviation,
	output logic [7:0]        target_heading
);

	logic [7:0] gain_q;
	logic       ready;
	logic       valid_s1;
	hdf_item_t  item_s1;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_COMPASS_GAIN) ? {24'd0, gain_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 8'd0;
		end else if (psel && penable && pwrite && pready && paddr == REG_COMPASS_GAIN) begin
			gain_q <= pwdata[7:0];
		end
	end

	hdf_intake u_intake (
		.clk           (clk),
		.arst_n        (arst_n),
		.heading_valid (heading_valid),
		.heading_stall (heading_stall),
		.sensor_ok     (sensor_ok),
		.heading_raw   (heading_raw),
		.ready         (ready),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1)
	);

	hdf_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.item_s1        (item_s1),
		.gain           (gain_q),
		.ready          (ready),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.deviation      (deviation),
		.target_heading (target_heading)
	);

endmodule
